FILE: rtl/cakb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cakb_pkg;

   localparam int MAX_DIM_DEFAULT = 4096;

   localparam int CHAN_W   = 8;
   localparam int DIM_W    = 13;
   localparam int STRIDE_W = 14;
   localparam int COORD_W  = 13;
   localparam int INDEX_W  = 25;
   localparam int PROD_W   = COORD_W + STRIDE_W;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 56;
   localparam int RSP_USER_W  = 1;

   localparam logic [CHAN_W-1:0] OPAQUE_ALPHA = 8'hFF;

   typedef enum logic [2:0] {
      REG_FRAME_WIDTH  = 3'd0,
      REG_FRAME_HEIGHT = 3'd1,
      REG_FRAME_STRIDE = 3'd2,
      REG_IMAGE_WIDTH  = 3'd3,
      REG_IMAGE_HEIGHT = 3'd4,
      REG_POS_X        = 3'd5,
      REG_POS_Y        = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [DIM_W-1:0]           frame_width;
      logic [DIM_W-1:0]           frame_height;
      logic [STRIDE_W-1:0]        frame_stride;
      logic [DIM_W-1:0]           image_width;
      logic [DIM_W-1:0]           image_height;
      logic signed [COORD_W-1:0]  pos_x;
      logic signed [COORD_W-1:0]  pos_y;
   } cfg_type;

   typedef struct packed {
      logic [CHAN_W-1:0] alpha;
      logic [CHAN_W-1:0] chan_c;
      logic [CHAN_W-1:0] chan_b;
      logic [CHAN_W-1:0] chan_a;
   } pixel_type;

   typedef struct packed {
      logic [CHAN_W-1:0]  out_c;
      logic [CHAN_W-1:0]  out_b;
      logic [CHAN_W-1:0]  out_a;
      logic [INDEX_W-1:0] pixel_index;
      logic               write_enable;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/cakb_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module cakb_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cakb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cakb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [cakb_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output cakb_pkg::cfg_type                   cfg
);
   import cakb_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          write_strobe;

   assign csr_pready   = 1'b1;
   assign reg_index    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign write_strobe = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_strobe) begin
         unique case (reg_index)
            REG_FRAME_WIDTH:  cfg_in.frame_width  = csr_pwdata[DIM_W-1:0];
            REG_FRAME_HEIGHT: cfg_in.frame_height = csr_pwdata[DIM_W-1:0];
            REG_FRAME_STRIDE: cfg_in.frame_stride = csr_pwdata[STRIDE_W-1:0];
            REG_IMAGE_WIDTH:  cfg_in.image_width  = csr_pwdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT: cfg_in.image_height = csr_pwdata[DIM_W-1:0];
            REG_POS_X:        cfg_in.pos_x        = csr_pwdata[COORD_W-1:0];
            REG_POS_Y:        cfg_in.pos_y        = csr_pwdata[COORD_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.frame_width);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.frame_height);
         REG_FRAME_STRIDE: csr_prdata = CSR_DATA_W'(cfg_ff.frame_stride);
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.image_width);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_W'(cfg_ff.image_height);
         REG_POS_X:        csr_prdata = CSR_DATA_W'($unsigned(cfg_ff.pos_x));
         REG_POS_Y:        csr_prdata = CSR_DATA_W'($unsigned(cfg_ff.pos_y));
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= DIM_W'(1);
         cfg_ff.frame_height <= DIM_W'(1);
         cfg_ff.frame_stride <= STRIDE_W'(1);
         cfg_ff.image_width  <= DIM_W'(1);
         cfg_ff.image_height <= DIM_W'(1);
         cfg_ff.pos_x        <= '0;
         cfg_ff.pos_y        <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/cakb_core.sv
`timescale 1ns / 1ps
`default_nettype none

module cakb_core #(
   parameter int MAX_DIM = cakb_pkg::MAX_DIM_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cakb_pkg::cfg_type     cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  cakb_pkg::pixel_type   in_pixel,
   output logic                  out_valid,
   input  logic                  out_ready,
   output cakb_pkg::result_type  out_result
);
   import cakb_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int EFF_W = $clog2(MAX_DIM + 1);
   localparam int FX_W  = ((CNT_W + 1 > COORD_W) ? CNT_W + 1 : COORD_W) + 1;

   function automatic logic [EFF_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
      logic [EFF_W-1:0] r;
      if (v == '0) begin
         r = EFF_W'(1);
      end else if (32'(v) > 32'(MAX_DIM)) begin
         r = EFF_W'(MAX_DIM);
      end else begin
         r = EFF_W'(v);
      end
      return r;
   endfunction

   logic [CNT_W-1:0]        col_ff, col_in;
   logic [CNT_W-1:0]        row_ff, row_in;
   logic                    stage_valid_ff, stage_valid_in;
   result_type              stage_ff, stage_in;

   logic                    in_fire;
   logic [CNT_W:0]          col_inc;
   logic [CNT_W:0]          row_inc;
   logic signed [FX_W-1:0]  fx;
   logic signed [FX_W-1:0]  fy;
   logic                    in_frame;
   logic                    draw;
   logic [PROD_W-1:0]       prod;
   logic [PROD_W-1:0]       idx_sum;

   assign in_ready = !stage_valid_ff || out_ready;
   assign in_fire  = in_valid && in_ready;

   // raster counters: advance one column per request, wrap at the image size
   always_comb begin
      col_inc = {1'b0, col_ff} + (CNT_W + 1)'(1);
      row_inc = {1'b0, row_ff} + (CNT_W + 1)'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (in_fire) begin
         if (32'(col_inc) >= 32'(eff_dim(cfg.image_width))) begin
            col_in = '0;
            if (32'(row_inc) >= 32'(eff_dim(cfg.image_height))) begin
               row_in = '0;
            end else begin
               row_in = row_inc[CNT_W-1:0];
            end
         end else begin
            col_in = col_inc[CNT_W-1:0];
         end
      end
   end

   always_comb begin
      fx = $signed({{(FX_W - CNT_W){1'b0}}, col_ff}) + FX_W'(cfg.pos_x);
      fy = $signed({{(FX_W - CNT_W){1'b0}}, row_ff}) + FX_W'(cfg.pos_y);
      in_frame = !fx[FX_W-1] && (32'($unsigned(fx)) < 32'(cfg.frame_width)) &&
                 !fy[FX_W-1] && (32'($unsigned(fy)) < 32'(cfg.frame_height));
      draw = in_frame && (in_pixel.alpha == OPAQUE_ALPHA);
      // inside the frame both coordinates are below 2^13
      prod    = PROD_W'(fy[COORD_W-1:0]) * PROD_W'(cfg.frame_stride);
      idx_sum = prod + PROD_W'(fx[COORD_W-1:0]);

      stage_in = '0;
      if (draw) begin
         stage_in.write_enable = 1'b1;
         stage_in.pixel_index  = idx_sum[INDEX_W-1:0];
         stage_in.out_a        = in_pixel.chan_a;
         stage_in.out_b        = in_pixel.chan_b;
         stage_in.out_c        = in_pixel.chan_c;
      end
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (in_fire) begin
         stage_valid_in = 1'b1;
      end else if (out_ready) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         row_ff         <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         col_ff         <= col_in;
         row_ff         <= row_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid  = stage_valid_ff;
   assign out_result = stage_ff;

`ifndef SYNTHESIS
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      in_fire |=> stage_valid_ff)
      else $error("accepted request did not reach the result stage");

   a_stall_keeps_stage: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !out_ready |=> stage_valid_ff && $stable(stage_ff))
      else $error("result stage changed while downstream stalled");

   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !stage_ff.write_enable |->
         stage_ff.pixel_index == '0 && stage_ff.out_a == '0 &&
         stage_ff.out_b == '0 && stage_ff.out_c == '0)
      else $error("skipped pixel carries nonzero payload");
`endif

endmodule

`default_nettype wire

FILE: rtl/cakb_skid.sv
`timescale 1ns / 1ps
`default_nettype none

module cakb_skid (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  cakb_pkg::result_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output cakb_pkg::result_type  out_data
);
   import cakb_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       in_fire;
   logic       out_free;

   assign in_ready = !skid_valid_ff;
   assign in_fire  = in_valid && in_ready;
   assign out_free = !out_valid_ff || out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            // drain the held request first
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_fire;
            out_data_in  = in_data;
         end
      end else if (in_fire) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      in_fire && out_valid_ff && !out_ready |=> skid_valid_ff)
      else $error("request accepted under stall was not held");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_ready |=> out_valid_ff && !skid_valid_ff)
      else $error("skid entry did not move to the output register");
`endif

endmodule

`default_nettype wire

FILE: rtl/clipped_alpha_key_blit.sv
`timescale 1ns / 1ps
`default_nettype none

// Alpha-keyed sprite blit with frame clipping.
// req_*: source pixels in raster order, one request per pixel. The block
//    counts column and row itself, wrapping at image_width / image_height.
// rsp_*: one result per pixel. rsp_tuser is the write enable; when it is low
//    the index and channels are zero. The byte address is 4 * pixel_index.
// csr_*: register file for frame size, stride, image size and position;
//    write it only while no pixel is in flight.
// A request passes from acceptance to rsp_tvalid through one result stage
// holding the clip test and the row-times-stride multiply, then an output
// register. Throughput is one pixel per clock while the receiver does not stall.
// When the receiver stalls, a skid entry behind the output register takes
// one more request; after that the result stage fills and req_tready drops.
// No result is dropped or repeated.
// Reset empties the pipeline, clears the column and row counters and sets the
// sizes and stride to 1 and the position to 0.

module clipped_alpha_key_blit #(
   parameter int MAX_DIM = cakb_pkg::MAX_DIM_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] chan_a, [15:8] chan_b, [23:16] chan_c, [31:24] alpha
   input  logic [cakb_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [24:0] pixel_index, [32:25] out_a, [40:33] out_b, [48:41] out_c,
   // [55:49] zero
   output logic [cakb_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // [0] write_enable
   output logic [cakb_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cakb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cakb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [cakb_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import cakb_pkg::*;

   cfg_type    cfg;
   pixel_type  pixel;
   logic       stage_valid;
   logic       stage_ready;
   result_type stage_result;
   result_type rsp_result;

   assign pixel = pixel_type'(req_tdata);

   cakb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cakb_core #(
      .MAX_DIM (MAX_DIM)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_pixel   (pixel),
      .out_valid  (stage_valid),
      .out_ready  (stage_ready),
      .out_result (stage_result)
   );

   cakb_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid),
      .in_ready  (stage_ready),
      .in_data   (stage_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_result)
   );

   assign rsp_tdata = {7'd0, rsp_result.out_c, rsp_result.out_b, rsp_result.out_a,
                       rsp_result.pixel_index};
   assign rsp_tuser = rsp_result.write_enable;

endmodule

`default_nettype wire
